/* rtl/median_filter_3x3_assert.svh */
// Assertion macros shared by the median filter modules.
// Each expects signals named clk and arst_n in the enclosing module.
`ifndef MEDIAN_FILTER_3X3_ASSERT_SVH
`define MEDIAN_FILTER_3X3_ASSERT_SVH

// cons must hold in the same cycle as ante
`define MF_ASSERT_IMPLY(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// cons must hold in the cycle after ante
`define MF_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

// cond must never hold
`define MF_ASSERT_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error(msg);

`endif

/* rtl/mf_pkg.sv */
package mf_pkg;

	// fixed field widths
	localparam int COL_BITS      = 10;
	localparam int ROW_BITS      = 12;
	localparam int CFG_W_BITS    = 11;
	localparam int CFG_H_BITS    = 13;
	localparam int CFG_DATA_BITS = 13;
	localparam int CFG_IDX_BITS  = 1;
	localparam int MAX_HEIGHT    = 4096;

	// register reset values
	localparam logic [CFG_W_BITS-1:0] WIDTH_RESET  = 11'd640;
	localparam logic [CFG_H_BITS-1:0] HEIGHT_RESET = 13'd480;

	// register indexes
	localparam logic [CFG_IDX_BITS-1:0] REG_FRAME_WIDTH  = 1'b0;
	localparam logic [CFG_IDX_BITS-1:0] REG_FRAME_HEIGHT = 1'b1;

	// item kinds on the input tuser
	localparam logic REQ_PIXEL = 1'b0;
	localparam logic REQ_DRAIN = 1'b1;

	// what one item asks of the median pipeline
	typedef struct packed {
		logic                r0_v;     // result for the column left of the newest
		logic                r1_v;     // result for the newest column (row end)
		logic                r0_lsel;  // r0 left neighbor clamps to center column
		logic                r1_lsel;  // r1 left neighbor clamps to newest column
		logic [COL_BITS-1:0] col;      // column of the newest window column
		logic [ROW_BITS-1:0] row;      // row of the results
		logic                final_px; // last result of the frame
	} res_ctrl_t;

endpackage

/* rtl/mf_ram.sv */
module mf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// one write port, one registered read port (old data on collision)
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* rtl/mf_median.sv */
`include "median_filter_3x3_assert.svh"

module mf_median #(
	parameter int PB = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [2:0][2:0][PB-1:0]       win,    // [column][rank], column 2 newest
	input  mf_pkg::res_ctrl_t             ctrl,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [PB-1:0]                 median,
	output logic [mf_pkg::COL_BITS-1:0]   col,
	output logic [mf_pkg::ROW_BITS-1:0]   row,
	output logic                          run_last,
	output logic                          frame_last
);

	function automatic logic [PB-1:0] min2(input logic [PB-1:0] a, input logic [PB-1:0] b);
		return (a < b) ? a : b;
	endfunction

	function automatic logic [PB-1:0] max2(input logic [PB-1:0] a, input logic [PB-1:0] b);
		return (a > b) ? a : b;
	endfunction

	function automatic logic [PB-1:0] med3(input logic [PB-1:0] a, input logic [PB-1:0] b,
			input logic [PB-1:0] c);
		return max2(min2(a, b), min2(max2(a, b), c));
	endfunction

	// stage 2: snapshot of the sorted window
	logic                       v2_q;
	logic [2:0][2:0][PB-1:0]    win_s2;
	mf_pkg::res_ctrl_t          ctrl_s2;

	// stage 3: max of lows, median of mids, min of highs per result
	logic                       v3_q;
	logic [1:0][2:0][PB-1:0]    tri_s3;
	mf_pkg::res_ctrl_t          ctrl_s3;

	// output slots, slot 0 is shown
	logic [1:0][PB-1:0]                 med_q;
	logic [1:0][mf_pkg::COL_BITS-1:0]   col_q;
	logic [1:0][mf_pkg::ROW_BITS-1:0]   row_q;
	logic [1:0]                         rl_q;
	logic [1:0]                         fl_q;
	logic [1:0]                         cnt_q;

	logic adv2, adv3, out_free, pop;
	logic [1:0][2:0][PB-1:0] sel_cols;   // per result: max of lows, median of mids, min of highs
	logic [1:0][2:0][PB-1:0] tri_next;
	logic [1:0][2:0][2:0][PB-1:0] pick;  // [result][which column][rank]
	logic [PB-1:0] med0, med1;

	assign pop      = out_valid && out_ready;
	assign out_free = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && pop);
	assign adv3     = v3_q && out_free;
	assign adv2     = v2_q && (!v3_q || adv3);
	assign in_ready = !v2_q || adv2;

	// column choice with edge clamping, then per-rank max, median and min
	always_comb begin
		pick[0][0] = ctrl_s2.r0_lsel ? win_s2[1] : win_s2[0];
		pick[0][1] = win_s2[1];
		pick[0][2] = win_s2[2];
		pick[1][0] = ctrl_s2.r1_lsel ? win_s2[2] : win_s2[1];
		pick[1][1] = win_s2[2];
		pick[1][2] = win_s2[2];
		for (int r = 0; r < 2; r++) begin
			tri_next[r][0] = max2(max2(pick[r][0][0], pick[r][1][0]), pick[r][2][0]);
			tri_next[r][1] = med3(pick[r][0][1], pick[r][1][1], pick[r][2][1]);
			tri_next[r][2] = min2(min2(pick[r][0][2], pick[r][1][2]), pick[r][2][2]);
		end
		sel_cols = tri_next;
	end

	assign med0 = med3(tri_s3[0][0], tri_s3[0][1], tri_s3[0][2]);
	assign med1 = med3(tri_s3[1][0], tri_s3[1][1], tri_s3[1][2]);

	// pipeline valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v2_q <= 1'b0;
			v3_q <= 1'b0;
		end else begin
			if (in_ready) begin
				v2_q <= in_valid;
			end
			if (adv2) begin
				v3_q <= 1'b1;
			end else if (adv3) begin
				v3_q <= 1'b0;
			end
		end
	end

	// pipeline payload
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			win_s2  <= win;
			ctrl_s2 <= ctrl;
		end
		if (adv2) begin
			tri_s3  <= sel_cols;
			ctrl_s3 <= ctrl_s2;
		end
	end

	// output slot count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (adv3) begin
			cnt_q <= (ctrl_s3.r0_v && ctrl_s3.r1_v) ? 2'd2 : 2'd1;
		end else if (pop) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	// output slot payload
	always_ff @(posedge clk) begin
		if (adv3) begin
			if (ctrl_s3.r0_v) begin
				med_q[0] <= med0;
				col_q[0] <= ctrl_s3.col - mf_pkg::COL_BITS'(1);
				rl_q[0]  <= !ctrl_s3.r1_v;
				fl_q[0]  <= !ctrl_s3.r1_v && ctrl_s3.final_px;
			end else begin
				med_q[0] <= med1;
				col_q[0] <= ctrl_s3.col;
				rl_q[0]  <= 1'b1;
				fl_q[0]  <= ctrl_s3.final_px;
			end
			row_q[0] <= ctrl_s3.row;
			med_q[1] <= med1;
			col_q[1] <= ctrl_s3.col;
			row_q[1] <= ctrl_s3.row;
			rl_q[1]  <= 1'b1;
			fl_q[1]  <= ctrl_s3.final_px;
		end else if (pop && (cnt_q == 2'd2)) begin
			med_q[0] <= med_q[1];
			col_q[0] <= col_q[1];
			row_q[0] <= row_q[1];
			rl_q[0]  <= rl_q[1];
			fl_q[0]  <= fl_q[1];
		end
	end

	assign out_valid  = (cnt_q != 2'd0);
	assign median     = med_q[0];
	assign col        = col_q[0];
	assign row        = row_q[0];
	assign run_last   = rl_q[0];
	assign frame_last = fl_q[0];

	`MF_ASSERT_NEVER(a_cnt_range, cnt_q == 2'd3, "output slot count out of range")
	`MF_ASSERT_IMPLY(a_s3_has_result, adv3, ctrl_s3.r0_v || ctrl_s3.r1_v, "empty item in stage 3")

endmodule

/* rtl/median_filter_3x3.sv */
// 3x3 median filter over a raster pixel stream.
// Input channel s_*: one item per accept; tuser = 0 for a pixel, 1 for a drain step.
// Pixels of a frame arrive row by row; after the last row, frame_width drain items
// flush it. Pixels sent during the drain and drain items sent outside it are dropped.
// Output channel m_*: results for row y appear while row y+1 streams in; each item
// gives zero, one or two results, tlast marks the last result of an item and tuser
// marks the last result of the frame.
// Items pass stage 1 and the median pipeline; results wait in an output slot.
// Throughput: one item per cycle while the output takes results; the item ending a
// row gives two results, which leave in turn and hold the input back. The rate is set
// by the single write port of each line store: a pixel item writes its column at most
// once per store; forwarding covers a read of the entry just written. The median is a
// sorting network fed by a window of sorted columns. Reset clears the counters, the
// window and the pipeline; the line stores are not cleared and need no sweep.
// frame_width and frame_height reset to 640 and 480 and are written through cfg_*;
// the user must do so only while the block is idle, which the block does not
// enforce. A stalled output holds its result; the pipeline backs up and s_tready drops.
`include "median_filter_3x3_assert.svh"

module median_filter_3x3 #(
	parameter int MAX_WIDTH  = 1024,
	parameter int PIXEL_BITS = 8
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// configuration writes
	input  logic                               cfg_we,
	input  logic [mf_pkg::CFG_IDX_BITS-1:0]    cfg_idx,
	input  logic [mf_pkg::CFG_DATA_BITS-1:0]   cfg_data,
	// input items
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [((PIXEL_BITS+7)/8)*8-1:0]    s_tdata,  // pixel_value
	input  logic                               s_tuser,  // req_type
	// result items
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [((PIXEL_BITS+22+7)/8)*8-1:0] m_tdata,  // median_value, out_col, out_row
	output logic                               m_tlast,  // run_last
	output logic                               m_tuser   // frame_last
);

	localparam int CW    = $clog2(MAX_WIDTH);
	localparam int WB    = $clog2(MAX_WIDTH + 1);
	localparam int OUT_W = ((PIXEL_BITS + 22 + 7) / 8) * 8;

	function automatic logic [2:0][PIXEL_BITS-1:0] sort3(input logic [PIXEL_BITS-1:0] a,
			input logic [PIXEL_BITS-1:0] b, input logic [PIXEL_BITS-1:0] c);
		logic [PIXEL_BITS-1:0] x, y, z, t;
		x = a;
		y = b;
		z = c;
		if (x > y) begin
			t = x; x = y; y = t;
		end
		if (y > z) begin
			t = y; y = z; z = t;
		end
		if (x > y) begin
			t = x; x = y; y = t;
		end
		return {z, y, x};
	endfunction

	// configuration
	logic [mf_pkg::CFG_W_BITS-1:0] cfg_width_q;
	logic [mf_pkg::CFG_H_BITS-1:0] cfg_height_q;
	logic [WB-1:0]                 w_eff;
	logic [mf_pkg::CFG_H_BITS-1:0] h_eff;

	// frame position
	logic [CW-1:0]               col_q;
	logic [CW-1:0]               drain_q;
	logic [mf_pkg::ROW_BITS-1:0] row_q;
	logic                        draining_q;

	// stage 0 decode
	logic          is_pix, act, accept, last_col, last_row;
	logic [CW-1:0] cur;
	mf_pkg::res_ctrl_t res_d;

	// stage 1: line store read data arrives
	logic                  v1_q;
	logic [CW-1:0]         addr_s1;
	logic [PIXEL_BITS-1:0] pix_s1;
	logic                  shift_s1, wr_prior_s1, wr_older_s1, top_mid_s1, bot_mid_s1;
	mf_pkg::res_ctrl_t     res_s1;
	logic                  fwdp_v_s1, fwdo_v_s1;
	logic [PIXEL_BITS-1:0] fwdp_d_s1, fwdo_d_s1;
	logic                  s1_has_res, adv1, med_ready;

	logic [PIXEL_BITS-1:0] prior_rdata, older_rdata;
	logic [PIXEL_BITS-1:0] mid, top, bot;
	logic [2:0][2:0][PIXEL_BITS-1:0] win_q, win_next;

	logic [PIXEL_BITS-1:0]       med_val;
	logic [mf_pkg::COL_BITS-1:0] med_col;
	logic [mf_pkg::ROW_BITS-1:0] med_row;

	// clamp register values to the usable range
	always_comb begin
		if (cfg_width_q == '0) begin
			w_eff = WB'(1);
		end else if (32'(cfg_width_q) > 32'(MAX_WIDTH)) begin
			w_eff = WB'(MAX_WIDTH);
		end else begin
			w_eff = WB'(cfg_width_q);
		end
		if (cfg_height_q == '0) begin
			h_eff = mf_pkg::CFG_H_BITS'(1);
		end else if (32'(cfg_height_q) > 32'(mf_pkg::MAX_HEIGHT)) begin
			h_eff = mf_pkg::CFG_H_BITS'(mf_pkg::MAX_HEIGHT);
		end else begin
			h_eff = cfg_height_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_width_q  <= mf_pkg::WIDTH_RESET;
			cfg_height_q <= mf_pkg::HEIGHT_RESET;
		end else if (cfg_we) begin
			case (cfg_idx)
				mf_pkg::REG_FRAME_WIDTH: begin
					cfg_width_q <= cfg_data[mf_pkg::CFG_W_BITS-1:0];
				end
				mf_pkg::REG_FRAME_HEIGHT: begin
					cfg_height_q <= cfg_data;
				end
				default: begin
				end
			endcase
		end
	end

	// stage 0: decide what the item does
	assign is_pix   = (s_tuser == mf_pkg::REQ_PIXEL);
	assign act      = is_pix ? !draining_q : draining_q;
	assign cur      = draining_q ? drain_q : col_q;
	assign last_col = (32'(cur) + 32'd1) >= 32'(w_eff);
	assign last_row = (32'(row_q) + 32'd1) >= 32'(h_eff);

	always_comb begin
		logic shift;
		shift          = is_pix ? (row_q != '0) : 1'b1;
		res_d.r0_v     = shift && (cur != '0);
		res_d.r1_v     = shift && last_col;
		res_d.r0_lsel  = (32'(cur) < 32'd2);
		res_d.r1_lsel  = (cur == '0);
		res_d.col      = mf_pkg::COL_BITS'(cur);
		res_d.row      = is_pix ? (row_q - mf_pkg::ROW_BITS'(1)) : row_q;
		res_d.final_px = !is_pix && last_col;
	end

	assign s1_has_res = res_s1.r0_v || res_s1.r1_v;
	assign adv1       = v1_q && (!s1_has_res || med_ready);
	assign s_tready   = !v1_q || adv1;
	assign accept     = s_tvalid && s_tready;

	// frame position counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q      <= '0;
			drain_q    <= '0;
			row_q      <= '0;
			draining_q <= 1'b0;
		end else if (accept && act) begin
			if (is_pix) begin
				if (last_col) begin
					col_q <= '0;
					if (last_row) begin
						draining_q <= 1'b1;
						drain_q    <= '0;
					end else begin
						row_q <= row_q + mf_pkg::ROW_BITS'(1);
					end
				end else begin
					col_q <= col_q + CW'(1);
				end
			end else begin
				if (last_col) begin
					draining_q <= 1'b0;
					drain_q    <= '0;
					col_q      <= '0;
					row_q      <= '0;
				end else begin
					drain_q <= drain_q + CW'(1);
				end
			end
		end
	end

	// stage 1 valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
		end else if (s_tready) begin
			v1_q <= s_tvalid && act;
		end
	end

	// stage 1 payload, with forwarding of the write leaving stage 1 this edge
	always_ff @(posedge clk) begin
		if (accept) begin
			addr_s1     <= cur;
			pix_s1      <= s_tdata[PIXEL_BITS-1:0];
			shift_s1    <= is_pix ? (row_q != '0) : 1'b1;
			wr_prior_s1 <= is_pix;
			wr_older_s1 <= is_pix && (row_q != '0);
			top_mid_s1  <= is_pix ? (row_q == mf_pkg::ROW_BITS'(1)) : (row_q == '0);
			bot_mid_s1  <= !is_pix;
			res_s1      <= res_d;
			fwdp_v_s1   <= adv1 && wr_prior_s1 && (addr_s1 == cur);
			fwdp_d_s1   <= pix_s1;
			fwdo_v_s1   <= adv1 && wr_older_s1 && (addr_s1 == cur);
			fwdo_d_s1   <= mid;
		end
	end

	// line stores
	mf_ram #(
		.WIDTH(PIXEL_BITS),
		.DEPTH(MAX_WIDTH)
	) u_prior_ram (
		.clk  (clk),
		.we   (adv1 && wr_prior_s1),
		.waddr(addr_s1),
		.wdata(pix_s1),
		.re   (accept && act),
		.raddr(cur),
		.rdata(prior_rdata)
	);

	mf_ram #(
		.WIDTH(PIXEL_BITS),
		.DEPTH(MAX_WIDTH)
	) u_older_ram (
		.clk  (clk),
		.we   (adv1 && wr_older_s1),
		.waddr(addr_s1),
		.wdata(mid),
		.re   (accept && act),
		.raddr(cur),
		.rdata(older_rdata)
	);

	// new window column, clamped at top and bottom, then sorted
	assign mid = fwdp_v_s1 ? fwdp_d_s1 : prior_rdata;
	assign top = top_mid_s1 ? mid : (fwdo_v_s1 ? fwdo_d_s1 : older_rdata);
	assign bot = bot_mid_s1 ? mid : pix_s1;

	always_comb begin
		win_next[0] = win_q[1];
		win_next[1] = win_q[2];
		win_next[2] = sort3(top, mid, bot);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= '0;
		end else if (adv1 && shift_s1) begin
			win_q <= win_next;
		end
	end

	// median pipeline and output slots
	mf_median #(
		.PB(PIXEL_BITS)
	) u_median (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v1_q && s1_has_res),
		.in_ready  (med_ready),
		.win       (win_next),
		.ctrl      (res_s1),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.median    (med_val),
		.col       (med_col),
		.row       (med_row),
		.run_last  (m_tlast),
		.frame_last(m_tuser)
	);

	assign m_tdata = OUT_W'({med_row, med_col, med_val});

	`MF_ASSERT_IMPLY(a_drain_col_zero, draining_q, col_q == '0, "column count set during drain")
	`MF_ASSERT_IMPLY(a_idle_drain_zero, !draining_q, drain_q == '0, "drain count set outside drain")
	`MF_ASSERT_NEXT(a_s1_hold, v1_q && !adv1, v1_q && $stable(res_s1) && $stable(addr_s1), "stage 1 changed while stalled")

endmodule

/* dv/median_filter_3x3_tb.sv */
`timescale 1ns / 100ps

module median_filter_3x3_tb;

	localparam int LINE_MAX     = 1024;
	localparam int IDLE_LIMIT   = 2000;
	localparam int SETTLE       = 10;
	localparam int RANDOM_ITEMS = 560;
	localparam int REPORT_MAX   = 10;

	typedef enum int {TEX_NOISE, TEX_BINARY, TEX_FLAT} texture_t;

	typedef struct packed {
		logic       kind;
		logic [7:0] pix;
	} pixel_item_t;

	typedef struct packed {
		logic [7:0]                  med;
		logic [mf_pkg::COL_BITS-1:0] col;
		logic [mf_pkg::ROW_BITS-1:0] row;
		logic                        last;
		logic                        flast;
	} median_res_t;

	logic                             clk      = 1'b0;
	logic                             arst_n   = 1'b0;
	logic                             cfg_we   = 1'b0;
	logic [mf_pkg::CFG_IDX_BITS-1:0]  cfg_idx  = mf_pkg::REG_FRAME_WIDTH;
	logic [mf_pkg::CFG_DATA_BITS-1:0] cfg_data = '0;
	logic                             s_tvalid = 1'b0;
	logic                             s_tready;
	logic [7:0]                       s_tdata  = '0;  // pixel_value
	logic                             s_tuser  = mf_pkg::REQ_PIXEL;  // req_type
	logic                             m_tvalid;
	logic                             m_tready = 1'b0;
	logic [31:0]                      m_tdata;  // median_value, out_col, out_row
	logic                             m_tlast;  // run_last
	logic                             m_tuser;  // frame_last

	median_filter_3x3 uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

	// stimulus and expectation stores
	pixel_item_t pixel_q [$];
	median_res_t median_q [$];

	int err_count   = 0;
	int idle_cycles = 0;
	int stim_items  = 0;
	int gap_left    = 0;
	int stall_left  = 0;
	bit item_taken  = 1'b0;
	bit quiet       = 1'b0;

	// filter state mirror
	logic [7:0]                    older_line [LINE_MAX];
	logic [7:0]                    prior_line [LINE_MAX];
	logic [7:0]                    win [9];
	int                            col_cnt   = 0;
	int                            row_cnt   = 0;
	int                            drain_cnt = 0;
	bit                            draining  = 1'b0;
	logic [mf_pkg::CFG_W_BITS-1:0] width_reg  = mf_pkg::WIDTH_RESET;
	logic [mf_pkg::CFG_H_BITS-1:0] height_reg = mf_pkg::HEIGHT_RESET;

	always #2 clk = ~clk;

	function automatic int eff_width();
		if (width_reg == '0) return 1;
		if (width_reg > LINE_MAX) return LINE_MAX;
		return int'(width_reg);
	endfunction

	function automatic int eff_height();
		if (height_reg == '0) return 1;
		if (height_reg > mf_pkg::MAX_HEIGHT) return mf_pkg::MAX_HEIGHT;
		return int'(height_reg);
	endfunction

	// median of three window columns, each given as left, center, right slot
	function automatic logic [7:0] median9(int lc, int cc, int rc);
		logic [7:0] t [9];
		logic [7:0] s;
		for (int r = 0; r < 3; r++) begin
			t[r]     = win[lc*3 + r];
			t[3 + r] = win[cc*3 + r];
			t[6 + r] = win[rc*3 + r];
		end
		for (int i = 0; i < 9; i++) begin
			for (int j = i + 1; j < 9; j++) begin
				if (t[i] > t[j]) begin
					s    = t[i];
					t[i] = t[j];
					t[j] = s;
				end
			end
		end
		return t[4];
	endfunction

	// window moves left by one column, new column enters on the right
	task automatic shift_col(logic [7:0] top, logic [7:0] mid, logic [7:0] bot);
		win[0] = win[3]; win[3] = win[6]; win[6] = top;
		win[1] = win[4]; win[4] = win[7]; win[7] = mid;
		win[2] = win[5]; win[5] = win[8]; win[8] = bot;
	endtask

	// results once column c of the output row is in the window
	task automatic emit_results(int c, int w, int row, bit fin);
		median_res_t r;
		bit          row_end;
		row_end = (c + 1 >= w);
		if (c >= 1) begin
			r.med   = median9(c >= 2 ? 0 : 1, 1, 2);
			r.col   = mf_pkg::COL_BITS'(c - 1);
			r.row   = mf_pkg::ROW_BITS'(row);
			r.last  = !row_end;
			r.flast = !row_end && fin;
			median_q.push_back(r);
		end
		if (row_end) begin
			r.med   = median9(c == 0 ? 2 : 1, 2, 2);
			r.col   = mf_pkg::COL_BITS'(c);
			r.row   = mf_pkg::ROW_BITS'(row);
			r.last  = 1'b1;
			r.flast = fin;
			median_q.push_back(r);
		end
	endtask

	// advance the mirror by one accepted item
	task automatic filter_item(logic kind, logic [7:0] pix);
		int         w;
		int         h;
		int         c;
		int         i;
		logic [7:0] mid;
		bit         fin;
		w = eff_width();
		h = eff_height();
		if (kind == mf_pkg::REQ_PIXEL) begin
			if (!draining) begin
				c = col_cnt;
				i = (c < LINE_MAX) ? c : LINE_MAX - 1;
				if (row_cnt >= 1) begin
					mid = prior_line[i];
					shift_col(row_cnt == 1 ? mid : older_line[i], mid, pix);
					emit_results(c, w, row_cnt - 1, 1'b0);
					older_line[i] = mid;
				end
				prior_line[i] = pix;
				if (c + 1 >= w) begin
					col_cnt = 0;
					if (row_cnt + 1 >= h) begin
						draining  = 1'b1;
						drain_cnt = 0;
					end else begin
						row_cnt++;
					end
				end else begin
					col_cnt = c + 1;
				end
			end
		end else if (draining) begin
			c   = drain_cnt;
			i   = (c < LINE_MAX) ? c : LINE_MAX - 1;
			mid = prior_line[i];
			// bottom row clamps to the last row itself
			shift_col(row_cnt == 0 ? mid : older_line[i], mid, mid);
			fin = (c + 1 >= w);
			emit_results(c, w, row_cnt, fin);
			if (fin) begin
				draining  = 1'b0;
				drain_cnt = 0;
				col_cnt   = 0;
				row_cnt   = 0;
			end else begin
				drain_cnt = c + 1;
			end
		end
	endtask

	// mostly back to back, some short gaps, a few long ones
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (quiet || r < 65) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(4, 24);
	endfunction

	function automatic logic [7:0] texture(texture_t style, logic [7:0] base);
		case (style)
			TEX_BINARY: return $urandom_range(0, 1) ? 8'hFF : 8'h00;
			TEX_FLAT:   return base + 8'($urandom_range(0, 3));
			default:    return 8'($urandom_range(0, 255));
		endcase
	endfunction

	task automatic push_item(logic kind, logic [7:0] pix);
		pixel_item_t it;
		it.kind = kind;
		it.pix  = pix;
		pixel_q.push_back(it);
	endtask

	// register write at a falling edge; the block is idle here
	task automatic write_reg(logic [mf_pkg::CFG_IDX_BITS-1:0] idx, int val);
		@(negedge clk);
		cfg_we   <= 1'b1;
		cfg_idx  <= idx;
		cfg_data <= mf_pkg::CFG_DATA_BITS'(val);
		if (idx == mf_pkg::REG_FRAME_WIDTH) width_reg = mf_pkg::CFG_W_BITS'(val);
		else height_reg = mf_pkg::CFG_H_BITS'(val);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// hold off until all items went in and all results came out
	task automatic wait_idle();
		while (pixel_q.size() != 0 || s_tvalid || median_q.size() != 0) @(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	// one well-formed frame plus drain, optionally sprinkled with dropped items
	task automatic queue_frame(bit noisy);
		int         w;
		int         h;
		texture_t   style;
		logic [7:0] base;
		w     = eff_width();
		h     = eff_height();
		style = texture_t'($urandom_range(0, 2));
		base  = 8'($urandom_range(0, 255));
		@(posedge clk);
		for (int k = 0; k < w * h; k++) begin
			if (noisy && $urandom_range(0, 19) == 0)
				push_item(mf_pkg::REQ_DRAIN, 8'($urandom_range(0, 255)));
			push_item(mf_pkg::REQ_PIXEL, texture(style, base));
			stim_items++;
		end
		for (int d = 0; d < w; d++) begin
			if (noisy && $urandom_range(0, 19) == 0)
				push_item(mf_pkg::REQ_PIXEL, 8'($urandom_range(0, 255)));
			push_item(mf_pkg::REQ_DRAIN, 8'($urandom_range(0, 255)));
			stim_items++;
		end
		// stray drain after the frame closed
		if (noisy && $urandom_range(0, 3) == 0)
			push_item(mf_pkg::REQ_DRAIN, 8'($urandom_range(0, 255)));
	endtask

	// input driver
	always @(negedge clk) begin
		if (!s_tvalid || item_taken) begin
			if (gap_left > 0) begin
				s_tvalid <= 1'b0;
				gap_left--;
			end else if (pixel_q.size() > 0) begin
				s_tvalid <= 1'b1;
				s_tuser  <= pixel_q[0].kind;
				s_tdata  <= pixel_q[0].pix;
				gap_left = pick_gap();
			end else begin
				s_tvalid <= 1'b0;
			end
		end
		item_taken = 1'b0;
	end

	// accepted input items feed the mirror
	always @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			filter_item(s_tuser, s_tdata);
			void'(pixel_q.pop_front());
			item_taken = 1'b1;
		end
	end

	// output stalls
	always @(negedge clk) begin
		if (stall_left > 0) begin
			m_tready <= 1'b0;
			stall_left--;
		end else begin
			m_tready <= 1'b1;
			stall_left = pick_gap();
		end
	end

	// result checker
	always @(posedge clk) begin : result_check
		median_res_t got;
		median_res_t want;
		if (m_tvalid && m_tready) begin
			got.med   = m_tdata[7:0];
			got.col   = m_tdata[17:8];
			got.row   = m_tdata[29:18];
			got.last  = m_tlast;
			got.flast = m_tuser;
			if (median_q.size() == 0) begin
				err_count++;
				if (err_count <= REPORT_MAX)
					$display("%0t: unexpected med=%0d col=%0d row=%0d last=%0b flast=%0b",
						$realtime, got.med, got.col, got.row, got.last, got.flast);
			end else begin
				want = median_q.pop_front();
				if (got !== want) begin
					err_count++;
					if (err_count <= REPORT_MAX)
						$display("%0t: exp %0d/%0d/%0d/%0b/%0b got %0d/%0d/%0d/%0b/%0b",
							$realtime, want.med, want.col, want.row, want.last, want.flast,
							got.med, got.col, got.row, got.last, got.flast);
				end
			end
		end
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
		else idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("median_filter_3x3_tb: done, errors");
			$finish;
		end
	end

	// sequencer
	initial begin
		int wsel;
		int hsel;
		int frames;
		for (int i = 0; i < LINE_MAX; i++) begin
			older_line[i] = '0;
			prior_line[i] = '0;
		end
		for (int i = 0; i < 9; i++) win[i] = '0;

		repeat (3) @(negedge clk);
		arst_n <= 1'b1;

		// single-pixel frame: stray drain first, pixel dropped while draining
		write_reg(mf_pkg::REG_FRAME_WIDTH, 1);
		write_reg(mf_pkg::REG_FRAME_HEIGHT, 1);
		@(posedge clk);
		push_item(mf_pkg::REQ_DRAIN, 8'h5A);
		push_item(mf_pkg::REQ_PIXEL, 8'hFF);
		push_item(mf_pkg::REQ_PIXEL, 8'h00);
		push_item(mf_pkg::REQ_DRAIN, 8'hA5);
		wait_idle();

		// 3x2 frame with extreme values
		write_reg(mf_pkg::REG_FRAME_WIDTH, 3);
		write_reg(mf_pkg::REG_FRAME_HEIGHT, 2);
		@(posedge clk);
		push_item(mf_pkg::REQ_PIXEL, 8'h00);
		push_item(mf_pkg::REQ_PIXEL, 8'hFF);
		push_item(mf_pkg::REQ_PIXEL, 8'h80);
		push_item(mf_pkg::REQ_PIXEL, 8'hFF);
		push_item(mf_pkg::REQ_PIXEL, 8'h00);
		push_item(mf_pkg::REQ_PIXEL, 8'h11);
		for (int d = 0; d < 3; d++) push_item(mf_pkg::REQ_DRAIN, 8'h00);
		wait_idle();

		// width narrowed in the middle of a row
		write_reg(mf_pkg::REG_FRAME_WIDTH, 5);
		write_reg(mf_pkg::REG_FRAME_HEIGHT, 3);
		@(posedge clk);
		for (int k = 0; k < 7; k++) push_item(mf_pkg::REQ_PIXEL, 8'($urandom_range(0, 255)));
		wait_idle();
		write_reg(mf_pkg::REG_FRAME_WIDTH, 2);
		@(posedge clk);
		for (int k = 0; k < 3; k++) push_item(mf_pkg::REQ_PIXEL, 8'($urandom_range(0, 255)));
		for (int d = 0; d < 2; d++) push_item(mf_pkg::REQ_DRAIN, 8'h00);
		wait_idle();

		// zero settings act as one
		write_reg(mf_pkg::REG_FRAME_WIDTH, 0);
		write_reg(mf_pkg::REG_FRAME_HEIGHT, 0);
		queue_frame(1'b1);
		wait_idle();
		write_reg(mf_pkg::REG_FRAME_HEIGHT, 5);
		queue_frame(1'b0);
		wait_idle();
		write_reg(mf_pkg::REG_FRAME_WIDTH, 6);
		write_reg(mf_pkg::REG_FRAME_HEIGHT, 0);
		queue_frame(1'b1);
		wait_idle();

		// random frames, mostly small
		while (stim_items < RANDOM_ITEMS) begin
			wsel = $urandom_range(0, 99);
			hsel = $urandom_range(0, 99);
			if ($urandom_range(0, 3) != 0) begin
				if (wsel < 5) write_reg(mf_pkg::REG_FRAME_WIDTH, 0);
				else if (wsel < 75)
					write_reg(mf_pkg::REG_FRAME_WIDTH, $urandom_range(1, 12));
				else if (wsel < 95)
					write_reg(mf_pkg::REG_FRAME_WIDTH, $urandom_range(13, 40));
				else write_reg(mf_pkg::REG_FRAME_WIDTH, $urandom_range(41, 100));
			end
			if ($urandom_range(0, 3) != 0) begin
				if (hsel < 5) write_reg(mf_pkg::REG_FRAME_HEIGHT, 0);
				else if (eff_width() > 40)
					write_reg(mf_pkg::REG_FRAME_HEIGHT, $urandom_range(1, 2));
				else write_reg(mf_pkg::REG_FRAME_HEIGHT, $urandom_range(1, 6));
			end
			if (eff_width() * eff_height() > 120) write_reg(mf_pkg::REG_FRAME_HEIGHT, 1);
			quiet  = ($urandom_range(0, 3) == 0);
			frames = $urandom_range(1, 2);
			for (int f = 0; f < frames; f++) queue_frame($urandom_range(0, 2) != 0);
			wait_idle();
		end

		quiet = 1'b0;
		wait_idle();
		if (err_count == 0 && median_q.size() == 0) begin
			$display("median_filter_3x3_tb: done, clean");
		end else begin
			$display("median_filter_3x3_tb: done, errors");
		end
		$finish;
	end

endmodule
